// ----- rtl/core/jvcs_pkg.sv -----
`timescale 1ns / 1ps

package jvcs_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LIM,
        S_MUL_SF,
        S_ROUND,
        S_FIN
    } state_t;

    // Velocity component being shaped
    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_ROT
    } axis_sel_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_LINEAR_MAX   = 3'd0,
        REG_ROTATION_MAX = 3'd1,
        REG_LIMIT_STEP   = 3'd2,
        REG_SLOW_FACTOR  = 3'd3,
        REG_LIFT_SPEED   = 3'd4
    } cfg_reg_t;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;
    localparam int LIM_BITS      = 15;
    localparam int LIFT_BITS     = 7;
    localparam int LIFT_CMD_BITS = 8;

    // Drive request codes
    localparam logic [1:0] DR_NONE    = 2'd0;
    localparam logic [1:0] DR_ENABLE  = 2'd1;
    localparam logic [1:0] DR_DISABLE = 2'd2;

    // Register reset values
    localparam logic [LIM_BITS-1:0]  LINEAR_MAX_RST   = 15'd4096;
    localparam logic [LIM_BITS-1:0]  ROTATION_MAX_RST = 15'd4096;
    localparam logic [LIM_BITS-1:0]  LIMIT_STEP_RST   = 15'd410;
    localparam logic [LIM_BITS-1:0]  SLOW_FACTOR_RST  = 15'd8192;
    localparam logic [LIFT_BITS-1:0] LIFT_SPEED_RST   = 7'd0;

    // +1.0 and -1.0 in Q1.14, wide enough for axis widths up to 34 bits
    localparam logic signed [33:0] POS_ONE_Q14 = 34'sd16384;
    localparam logic signed [33:0] NEG_ONE_Q14 = -34'sd16384;

    // Rounding shifts for normal and slow mode
    localparam int SHIFT_NORMAL = 14;
    localparam int SHIFT_SLOW   = 28;

    typedef struct packed {
        logic      load;
        logic      mul_lim;
        logic      mul_sf;
        logic      round;
        logic      commit;
        axis_sel_t axis_sel;
    } cmd_t;

    typedef struct packed {
        logic slow;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/jvcs_ctrl.sv -----
`timescale 1ns / 1ps

module jvcs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jvcs_pkg::status_t  sts,
    output jvcs_pkg::cmd_t     cmd
);

    jvcs_pkg::state_t    state_reg, state_next;
    jvcs_pkg::axis_sel_t axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jvcs_pkg::S_IDLE;
            axis_reg  <= jvcs_pkg::AX_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.axis_sel = axis_reg;
        case (state_reg)
            jvcs_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    axis_next  = jvcs_pkg::AX_X;
                    state_next = jvcs_pkg::S_MUL_LIM;
                end
            end
            jvcs_pkg::S_MUL_LIM: begin
                cmd.mul_lim = 1'b1;
                state_next  = sts.slow ? jvcs_pkg::S_MUL_SF : jvcs_pkg::S_ROUND;
            end
            jvcs_pkg::S_MUL_SF: begin
                cmd.mul_sf = 1'b1;
                state_next = jvcs_pkg::S_ROUND;
            end
            jvcs_pkg::S_ROUND: begin
                cmd.round = 1'b1;
                case (axis_reg)
                    jvcs_pkg::AX_X: begin
                        axis_next  = jvcs_pkg::AX_Y;
                        state_next = jvcs_pkg::S_MUL_LIM;
                    end
                    jvcs_pkg::AX_Y: begin
                        axis_next  = jvcs_pkg::AX_ROT;
                        state_next = jvcs_pkg::S_MUL_LIM;
                    end
                    default: begin
                        state_next = jvcs_pkg::S_FIN;
                    end
                endcase
            end
            jvcs_pkg::S_FIN: begin
                // hold until the output register can take the transaction
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = jvcs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = jvcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/jvcs_dp.sv -----
`timescale 1ns / 1ps

module jvcs_dp #(
    parameter int AXIS_BITS = 16,
    parameter int VEL_BITS  = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  jvcs_pkg::cmd_t                              cmd,
    output jvcs_pkg::status_t                           sts,
    input  logic                                        s_btn_enable,
    input  logic                                        s_btn_disable,
    input  logic                                        s_btn_lift_up,
    input  logic                                        s_btn_lift_down,
    input  logic                                        s_btn_toggle_twist,
    input  logic                                        s_btn_dead_man,
    input  logic                                        s_btn_dead_man_slow,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_trans_x,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_trans_y,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_rot_z,
    input  logic signed [AXIS_BITS-1:0]                 s_dpad_north,
    input  logic signed [AXIS_BITS-1:0]                 s_dpad_west,
    input  logic                                        cfg_valid,
    input  logic [jvcs_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [jvcs_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                                        m_ready,
    output logic                                        m_valid,
    output logic [1:0]                                  m_drive_request,
    output logic                                        m_vel_valid,
    output logic signed [VEL_BITS-1:0]                  m_vel_x,
    output logic signed [VEL_BITS-1:0]                  m_vel_y,
    output logic signed [VEL_BITS-1:0]                  m_rot_z,
    output logic                                        m_lift_valid,
    output logic signed [jvcs_pkg::LIFT_CMD_BITS-1:0]   m_lift_cmd,
    output logic                                        m_twist_off
);

    localparam int LW = jvcs_pkg::LIM_BITS;
    localparam int MW = AXIS_BITS + LW;
    localparam int PW = MW + LW;
    localparam int SW = (VEL_BITS > LW) ? VEL_BITS : LW;
    localparam logic [PW:0] BIAS_NORMAL = (PW+1)'(1) << (jvcs_pkg::SHIFT_NORMAL - 1);
    localparam logic [PW:0] BIAS_SLOW   = (PW+1)'(1) << (jvcs_pkg::SHIFT_SLOW - 1);
    localparam logic [SW-1:0] VMAX = SW'({1'b0, {(VEL_BITS-1){1'b1}}});

    // configuration
    logic [LW-1:0]                  lin_max_reg, rot_max_reg, step_reg, sf_reg;
    logic [jvcs_pkg::LIFT_BITS-1:0] lift_speed_reg;

    // sample state
    logic                 seen_reg, prev_dm_reg, prev_dms_reg, prev_tog_reg;
    logic [AXIS_BITS-1:0] prev_dn_reg;
    logic                 twist_reg, zero_sent_reg;
    logic [LW-1:0]        lin_lim_reg, rot_lim_reg;

    // captured sample
    logic en_reg, dis_reg, up_reg, down_reg, tog_reg, dm_reg, dms_reg;
    logic [AXIS_BITS-1:0] ax_reg, ay_reg, ar_reg, dn_reg, dw_reg;

    // shaping
    logic [PW-1:0]       prod_reg;
    logic [VEL_BITS-1:0] vx_reg, vy_reg, rz_reg;
    logic                m_valid_reg;

    function automatic logic [LW-1:0] clamp_lim(
        input logic signed [LW+1:0] v,
        input logic [LW-1:0]        lo,
        input logic [LW-1:0]        hi
    );
        logic signed [LW+1:0] t;
        t = v;
        if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
        if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
        return t[LW-1:0];
    endfunction

    assign sts.slow     = dms_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_max_reg    <= jvcs_pkg::LINEAR_MAX_RST;
            rot_max_reg    <= jvcs_pkg::ROTATION_MAX_RST;
            step_reg       <= jvcs_pkg::LIMIT_STEP_RST;
            sf_reg         <= jvcs_pkg::SLOW_FACTOR_RST;
            lift_speed_reg <= jvcs_pkg::LIFT_SPEED_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                jvcs_pkg::REG_LINEAR_MAX:   lin_max_reg    <= cfg_data;
                jvcs_pkg::REG_ROTATION_MAX: rot_max_reg    <= cfg_data;
                jvcs_pkg::REG_LIMIT_STEP:   step_reg       <= cfg_data;
                jvcs_pkg::REG_SLOW_FACTOR:  sf_reg         <= cfg_data;
                jvcs_pkg::REG_LIFT_SPEED:   lift_speed_reg <= cfg_data[jvcs_pkg::LIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            en_reg   <= s_btn_enable;
            dis_reg  <= s_btn_disable;
            up_reg   <= s_btn_lift_up;
            down_reg <= s_btn_lift_down;
            tog_reg  <= s_btn_toggle_twist;
            dm_reg   <= s_btn_dead_man;
            dms_reg  <= s_btn_dead_man_slow;
            ax_reg   <= s_axis_trans_x;
            ay_reg   <= s_axis_trans_y;
            ar_reg   <= s_axis_rot_z;
            dn_reg   <= s_dpad_north;
            dw_reg   <= s_dpad_west;
        end
    end

    // ---- shared multiplier: |axis| * limit, then * slow factor in slow mode ----
    logic [AXIS_BITS-1:0] axis_val, axis_mag;
    logic [LW-1:0]        limit_val;
    logic                 axis_neg;
    logic [MW-1:0]        mul_a;
    logic [LW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;

    always_comb begin
        case (cmd.axis_sel)
            jvcs_pkg::AX_X: begin
                axis_val  = (dn_reg != '0) ? dn_reg : ax_reg;
                limit_val = lin_lim_reg;
            end
            jvcs_pkg::AX_Y: begin
                axis_val  = (dw_reg != '0) ? dw_reg : ay_reg;
                limit_val = lin_lim_reg;
            end
            default: begin
                axis_val  = ar_reg;
                limit_val = rot_lim_reg;
            end
        endcase
    end

    assign axis_neg = axis_val[AXIS_BITS-1];
    assign axis_mag = axis_neg ? AXIS_BITS'(~axis_val + 1'b1) : axis_val;
    assign mul_a    = cmd.mul_sf ? prod_reg[MW-1:0] : MW'(axis_mag);
    assign mul_b    = cmd.mul_sf ? sf_reg : limit_val;
    assign mul_p    = PW'(mul_a * mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_lim || cmd.mul_sf) begin
            prod_reg <= mul_p;
        end
    end

    // ---- round half away from zero, clamp to limit, saturate ----
    logic [PW:0]         rsum, rq;
    logic [LW-1:0]       pmag;
    logic [SW-1:0]       pext, psat;
    logic [VEL_BITS-1:0] pvel, vres;

    assign rsum = {1'b0, prod_reg} + (dms_reg ? BIAS_SLOW : BIAS_NORMAL);
    assign rq   = dms_reg ? (rsum >> jvcs_pkg::SHIFT_SLOW) : (rsum >> jvcs_pkg::SHIFT_NORMAL);
    assign pmag = (rq > (PW+1)'(limit_val)) ? limit_val : rq[LW-1:0];
    assign pext = SW'(pmag);
    assign psat = (pext > VMAX) ? VMAX : pext;
    assign pvel = psat[VEL_BITS-1:0];
    assign vres = axis_neg ? VEL_BITS'(~pvel + 1'b1) : pvel;

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            case (cmd.axis_sel)
                jvcs_pkg::AX_X: vx_reg <= vres;
                jvcs_pkg::AX_Y: vy_reg <= vres;
                default:        rz_reg <= vres;
            endcase
        end
    end

    // ---- per-sample decisions, applied at commit ----
    logic                   o_dm, o_dms, o_tog, dead, tw_new, vvalid, north, south;
    logic [AXIS_BITS-1:0]   o_dn;
    logic signed [33:0]     odn_w, dn_w;
    logic [1:0]             drive;
    logic [jvcs_pkg::LIFT_CMD_BITS-1:0] lift;
    logic signed [LW+1:0]   lin_sum, rot_sum;
    logic [LW-1:0]          lin_lim_next, rot_lim_next;
    logic                   zero_sent_next;

    assign o_dm  = seen_reg ? prev_dm_reg  : dm_reg;
    assign o_dms = seen_reg ? prev_dms_reg : dms_reg;
    assign o_tog = seen_reg ? prev_tog_reg : tog_reg;
    assign o_dn  = seen_reg ? prev_dn_reg  : dn_reg;
    assign odn_w = 34'($signed(o_dn));
    assign dn_w  = 34'($signed(dn_reg));

    assign dead   = dm_reg || dms_reg;
    assign tw_new = twist_reg ^ (tog_reg && !o_tog);
    assign vvalid = !tw_new && (dead || !zero_sent_reg);
    assign north  = !dead && (dn_w > 34'sd0) && (odn_w < jvcs_pkg::POS_ONE_Q14);
    assign south  = !dead && (dn_w < 34'sd0) && (odn_w > jvcs_pkg::NEG_ONE_Q14);

    always_comb begin
        if (dis_reg) begin
            drive = jvcs_pkg::DR_DISABLE;
        end else if (en_reg || (dm_reg && !o_dm) || (dms_reg && !o_dms)) begin
            drive = jvcs_pkg::DR_ENABLE;
        end else begin
            drive = jvcs_pkg::DR_NONE;
        end
    end

    always_comb begin
        lift = '0;
        if (!tw_new) begin
            if (up_reg) begin
                lift = {1'b0, lift_speed_reg};
            end else if (down_reg) begin
                lift = jvcs_pkg::LIFT_CMD_BITS'(~{1'b0, lift_speed_reg} + 1'b1);
            end
        end
    end

    assign zero_sent_next = tw_new ? zero_sent_reg : !dead;

    always_comb begin
        lin_sum = $signed({2'b00, lin_lim_reg});
        rot_sum = $signed({2'b00, rot_lim_reg});
        if (north) begin
            lin_sum = $signed({2'b00, lin_lim_reg}) + $signed({2'b00, step_reg});
            rot_sum = $signed({2'b00, rot_lim_reg}) + $signed({2'b00, step_reg});
        end else if (south) begin
            lin_sum = $signed({2'b00, lin_lim_reg}) - $signed({2'b00, step_reg});
            rot_sum = $signed({2'b00, rot_lim_reg}) - $signed({2'b00, step_reg});
        end
        lin_lim_next = (north || south) ? clamp_lim(lin_sum, step_reg, lin_max_reg)
                                        : lin_lim_reg;
        rot_lim_next = (north || south) ? clamp_lim(rot_sum, step_reg, rot_max_reg)
                                        : rot_lim_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            prev_dm_reg   <= 1'b0;
            prev_dms_reg  <= 1'b0;
            prev_tog_reg  <= 1'b0;
            prev_dn_reg   <= '0;
            twist_reg     <= 1'b0;
            zero_sent_reg <= 1'b0;
            lin_lim_reg   <= jvcs_pkg::LINEAR_MAX_RST;
            rot_lim_reg   <= jvcs_pkg::ROTATION_MAX_RST;
        end else if (cmd.commit) begin
            seen_reg      <= 1'b1;
            prev_dm_reg   <= dm_reg;
            prev_dms_reg  <= dms_reg;
            prev_tog_reg  <= tog_reg;
            prev_dn_reg   <= dn_reg;
            twist_reg     <= tw_new;
            zero_sent_reg <= zero_sent_next;
            lin_lim_reg   <= lin_lim_next;
            rot_lim_reg   <= rot_lim_next;
        end
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_drive_request <= drive;
            m_vel_valid     <= vvalid;
            m_vel_x         <= (vvalid && dead) ? vx_reg : '0;
            m_vel_y         <= (vvalid && dead) ? vy_reg : '0;
            m_rot_z         <= (vvalid && dead) ? rz_reg : '0;
            m_lift_valid    <= !tw_new;
            m_lift_cmd      <= lift;
            m_twist_off     <= tw_new;
        end
    end

endmodule

// ----- rtl/core/joystick_velocity_command_shaper_unit.sv -----
// Flow: after an input is taken, each velocity component passes through S_MUL_LIM,
// S_MUL_SF (slow dead man held only) and S_ROUND, then S_FIN commits once the output
// register can take it. No new input is taken until the controller returns to idle;
// one shared multiplier does one or two passes per velocity component, three components.
// Reset: synchronous active-low aresetn restores register defaults and limits.
`timescale 1ns / 1ps

module joystick_velocity_command_shaper_unit #(
    parameter int AXIS_BITS = 16,
    parameter int VEL_BITS  = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic                                        s_btn_enable,
    input  logic                                        s_btn_disable,
    input  logic                                        s_btn_lift_up,
    input  logic                                        s_btn_lift_down,
    input  logic                                        s_btn_toggle_twist,
    input  logic                                        s_btn_dead_man,
    input  logic                                        s_btn_dead_man_slow,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_trans_x,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_trans_y,
    input  logic signed [AXIS_BITS-1:0]                 s_axis_rot_z,
    input  logic signed [AXIS_BITS-1:0]                 s_dpad_north,
    input  logic signed [AXIS_BITS-1:0]                 s_dpad_west,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [jvcs_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [jvcs_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [1:0]                                  m_drive_request,
    output logic                                        m_vel_valid,
    output logic signed [VEL_BITS-1:0]                  m_vel_x,
    output logic signed [VEL_BITS-1:0]                  m_vel_y,
    output logic signed [VEL_BITS-1:0]                  m_rot_z,
    output logic                                        m_lift_valid,
    output logic signed [jvcs_pkg::LIFT_CMD_BITS-1:0]   m_lift_cmd,
    output logic                                        m_twist_off
);

    jvcs_pkg::cmd_t    cmd;
    jvcs_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    jvcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    jvcs_dp #(
        .AXIS_BITS (AXIS_BITS),
        .VEL_BITS  (VEL_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_btn_enable        (s_btn_enable),
        .s_btn_disable       (s_btn_disable),
        .s_btn_lift_up       (s_btn_lift_up),
        .s_btn_lift_down     (s_btn_lift_down),
        .s_btn_toggle_twist  (s_btn_toggle_twist),
        .s_btn_dead_man      (s_btn_dead_man),
        .s_btn_dead_man_slow (s_btn_dead_man_slow),
        .s_axis_trans_x      (s_axis_trans_x),
        .s_axis_trans_y      (s_axis_trans_y),
        .s_axis_rot_z        (s_axis_rot_z),
        .s_dpad_north        (s_dpad_north),
        .s_dpad_west         (s_dpad_west),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_drive_request     (m_drive_request),
        .m_vel_valid         (m_vel_valid),
        .m_vel_x             (m_vel_x),
        .m_vel_y             (m_vel_y),
        .m_rot_z             (m_rot_z),
        .m_lift_valid        (m_lift_valid),
        .m_lift_cmd          (m_lift_cmd),
        .m_twist_off         (m_twist_off)
    );

`ifndef SYNTHESIS
    // never overwrite a transaction still waiting at the output
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result committed over a pending transaction");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed result not presented");

    // lift is issued exactly when twist is enabled
    a_lift_twist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lift_valid == !m_twist_off))
        else $error("lift valid disagrees with twist flag");

    a_vel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_vel_valid) |-> (m_vel_x == '0 && m_vel_y == '0 && m_rot_z == '0))
        else $error("velocity nonzero without a velocity command");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_lim || cmd.mul_sf || cmd.round) |-> !s_ready)
        else $error("input accepted while shaping");
`endif

endmodule
